### sv/fbpa_pkg.sv
// ============================================================================
// fbpa_pkg - shared types and constants of the fixed block pool allocator
// Sizes of the pool, codes of the request and register words, and the
// control and status groups passed between the allocator's submodules.
// ============================================================================
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int BCNT_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [ADDR_W-1:0] BASE_RST  = '0;
  localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(64);
  localparam logic [BCNT_W-1:0] BCNT_RST  = BCNT_W'(64);
  localparam logic              EN_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_BLOCK_SIZE   = 2'd1,
    REG_BLOCK_COUNT  = 2'd2,
    REG_POOL_ENABLED = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC_WALK,
    ST_FREE_SCAN,
    ST_FINISH
  } fbpa_state_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_idx;
  } q_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] pop_idx;
    logic [CNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic load;
    logic step;
  } a_cmd_t;

  // Queue pointer advance with wrap at the pool depth.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (32'(idx) == MAX_BLOCKS - 1) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  // Tail position after a rebuild: block count modulo the pool depth.
  function automatic logic [IDX_W-1:0] tail_of(input logic [CNT_W-1:0] n);
    logic [IDX_W-1:0] res;
    if (32'(n) >= MAX_BLOCKS) begin
      res = '0;
    end else begin
      res = IDX_W'(n);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/fbpa_free_queue.sv
// ============================================================================
// fbpa_free_queue - FIFO of free block indices
// Memory of block indices with per-entry valid bits; an entry never written
// since the last rebuild reads as its own position.
// ============================================================================
`default_nettype none

module fbpa_free_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   rebuild,
  input  wire logic [fbpa_pkg::CNT_W-1:0] eff_n,
  input  wire fbpa_pkg::q_cmd_t       q_cmd,
  output fbpa_pkg::q_stat_t           q_stat
);

  logic [fbpa_pkg::IDX_W-1:0] mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::MAX_BLOCKS-1:0] valid_r;
  logic [fbpa_pkg::IDX_W-1:0] head_r;
  logic [fbpa_pkg::IDX_W-1:0] tail_r;
  logic [fbpa_pkg::CNT_W-1:0] count_r;
  logic [fbpa_pkg::IDX_W-1:0] rd_mem_r;
  logic                       rd_valid_r;
  logic [fbpa_pkg::IDX_W-1:0] rd_head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (rebuild) begin
      valid_r <= '0;
      head_r  <= '0;
      tail_r  <= fbpa_pkg::tail_of(eff_n);
      count_r <= eff_n;
    end else begin
      if (q_cmd.pop) begin
        head_r  <= fbpa_pkg::idx_inc(head_r);
        count_r <= count_r - fbpa_pkg::CNT_W'(1);
      end else if (q_cmd.push) begin
        valid_r[tail_r] <= 1'b1;
        tail_r          <= fbpa_pkg::idx_inc(tail_r);
        count_r         <= count_r + fbpa_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_cmd.push) begin
      mem[tail_r] <= q_cmd.push_idx;
    end
  end

  // Registered read of the oldest entry; the result holds until the next pop.
  always_ff @(posedge clk) begin
    if (q_cmd.pop) begin
      rd_mem_r   <= mem[head_r];
      rd_valid_r <= valid_r[head_r];
      rd_head_r  <= head_r;
    end
  end

  assign q_stat.pop_idx = rd_valid_r ? rd_mem_r : rd_head_r;
  assign q_stat.count   = count_r;

endmodule

`default_nettype wire

### sv/fbpa_addr_unit.sv
// ============================================================================
// fbpa_addr_unit - shared block address accumulator
// Steps the start address of block i by one block size per cycle while
// step is asserted, and compares it with the requested release address.
// ============================================================================
`default_nettype none

module fbpa_addr_unit (
  input  wire logic                        clk,
  input  wire fbpa_pkg::a_cmd_t            a_cmd,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] base_addr,
  input  wire logic [fbpa_pkg::SIZE_W-1:0] stride,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] want_in,
  output logic      [fbpa_pkg::ADDR_W-1:0] acc,
  output logic                             addr_match
);

  logic [fbpa_pkg::ADDR_W-1:0] acc_r;
  logic [fbpa_pkg::ADDR_W-1:0] want_r;

  always_ff @(posedge clk) begin
    if (a_cmd.load) begin
      acc_r  <= base_addr;
      want_r <= want_in;
    end else if (a_cmd.step) begin
      acc_r <= acc_r + fbpa_pkg::ADDR_W'(stride);
    end
  end

  assign acc        = acc_r;
  assign addr_match = (acc_r == want_r);

endmodule

`default_nettype wire

### sv/fbpa_ctrl.sv
// ============================================================================
// fbpa_ctrl - request sequencer of the block pool allocator
// Runs allocate walks and free scans over the shared address unit, keeps
// the in-use marks and holds the result word register.
// ============================================================================
`default_nettype none

module fbpa_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rebuild,
  input  wire logic [fbpa_pkg::CNT_W-1:0]  eff_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_action,
  input  wire logic                        addr_match,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] acc,
  input  wire fbpa_pkg::q_stat_t           q_stat,
  output fbpa_pkg::q_cmd_t                 q_cmd,
  output fbpa_pkg::a_cmd_t                 a_cmd,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_ok,
  output logic      [fbpa_pkg::ADDR_W-1:0] out_block_address,
  output logic      [fbpa_pkg::CNT_W-1:0]  out_free_blocks
);

  fbpa_pkg::fbpa_state_t state_r, state_nxt;

  logic [fbpa_pkg::IDX_W-1:0]      cnt_r;
  logic                            action_r;
  logic                            ok_r;
  logic [fbpa_pkg::MAX_BLOCKS-1:0] in_use_r;
  logic                            out_valid_r;
  logic                            out_ok_r;
  logic [fbpa_pkg::ADDR_W-1:0]     out_addr_r;
  logic [fbpa_pkg::CNT_W-1:0]      out_free_r;

  logic accept;
  logic walk_hit;
  logic scan_hit;
  logic scan_last;
  logic load_out;

  always_comb begin
    accept    = (state_r == fbpa_pkg::ST_IDLE) && !rebuild && in_valid;
    walk_hit  = (state_r == fbpa_pkg::ST_ALLOC_WALK) && (cnt_r == q_stat.pop_idx);
    scan_hit  = (state_r == fbpa_pkg::ST_FREE_SCAN) && in_use_r[cnt_r] && addr_match;
    scan_last = (fbpa_pkg::CNT_W'(cnt_r) + fbpa_pkg::CNT_W'(1)) == eff_n;
    load_out  = (state_r == fbpa_pkg::ST_FINISH) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbpa_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == fbpa_pkg::ACT_ALLOC) begin
            state_nxt = (q_stat.count != '0) ? fbpa_pkg::ST_ALLOC_WALK
                                             : fbpa_pkg::ST_FINISH;
          end else begin
            state_nxt = (eff_n != '0) ? fbpa_pkg::ST_FREE_SCAN : fbpa_pkg::ST_FINISH;
          end
        end
      end
      fbpa_pkg::ST_ALLOC_WALK: begin
        if (walk_hit) begin
          state_nxt = fbpa_pkg::ST_FINISH;
        end
      end
      fbpa_pkg::ST_FREE_SCAN: begin
        if (scan_hit || scan_last) begin
          state_nxt = fbpa_pkg::ST_FINISH;
        end
      end
      fbpa_pkg::ST_FINISH: begin
        if (load_out) begin
          state_nxt = fbpa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fbpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != fbpa_pkg::ST_IDLE) || rebuild;
    q_cmd.pop      = accept && (in_action == fbpa_pkg::ACT_ALLOC) && (q_stat.count != '0);
    q_cmd.push     = scan_hit;
    q_cmd.push_idx = cnt_r;
    a_cmd.load     = accept;
    a_cmd.step     = ((state_r == fbpa_pkg::ST_ALLOC_WALK) && !walk_hit) ||
                     ((state_r == fbpa_pkg::ST_FREE_SCAN) && !scan_hit && !scan_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::ST_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rebuild) begin
        in_use_r <= '0;
      end else if (walk_hit) begin
        in_use_r[q_stat.pop_idx] <= 1'b1;
      end else if (scan_hit) begin
        in_use_r[cnt_r] <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r    <= '0;
      ok_r     <= 1'b0;
      action_r <= in_action;
    end else begin
      if (a_cmd.step) begin
        cnt_r <= cnt_r + fbpa_pkg::IDX_W'(1);
      end
      if (walk_hit || scan_hit) begin
        ok_r <= 1'b1;
      end
    end
    if (load_out) begin
      out_ok_r   <= ok_r;
      out_addr_r <= (ok_r && (action_r == fbpa_pkg::ACT_ALLOC)) ? acc : '0;
      out_free_r <= q_stat.count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_block_address = out_addr_r;
  assign out_free_blocks   = out_free_r;

endmodule

`default_nettype wire

### sv/fixed_block_pool_allocator.sv
// ============================================================================
// fixed_block_pool_allocator - fixed-size block pool with a free queue
// Hands out and takes back equal-size blocks laid out from a base address,
// keeping free block indices in first-in-first-out order.
// ============================================================================
//
//   Channel  Direction  Handshake          Word
//   in_      sink       in_valid/in_stall  action, release_address
//   out_     source     out_valid/out_stall ok, block_address, free_blocks
//   cfg_     sink       cfg_valid/cfg_ready index, data (ready is always high)
//
// An allocate pops the oldest index from the free queue at its acceptance;
// the shared address accumulator then adds one block size per cycle until
// it reaches that block, and the result register is loaded in the finish
// state. A free walks the same accumulator over the blocks in order until
// an in-use block starts at the given address or the last of the effective
// blocks is reached. A request on an empty or disabled pool goes straight
// to the finish state.
// Reset and every configuration write rebuild the pool in one cycle, during
// which no word is accepted. A stalled result waits in the output register;
// the next word is accepted in the cycle after that result has been loaded.
// ============================================================================
`default_nettype none

module fixed_block_pool_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    in_release_address,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_ok,
  output logic      [fbpa_pkg::ADDR_W-1:0]    out_block_address,
  output logic      [fbpa_pkg::CNT_W-1:0]     out_free_blocks,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [fbpa_pkg::ADDR_W-1:0] base_r;
  logic [fbpa_pkg::SIZE_W-1:0] size_r;
  logic [fbpa_pkg::BCNT_W-1:0] bcount_r;
  logic                        enable_r;
  logic                        rebuild_r;
  logic [fbpa_pkg::CNT_W-1:0]  eff_n;
  logic                        cfg_we;

  fbpa_pkg::q_cmd_t  q_cmd;
  fbpa_pkg::q_stat_t q_stat;
  fbpa_pkg::a_cmd_t  a_cmd;
  logic [fbpa_pkg::ADDR_W-1:0] acc;
  logic                        addr_match;

  // Configuration is only to be written while the pool is idle, so the port
  // never needs to push back; the block itself does not enforce this.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= fbpa_pkg::BASE_RST;
      size_r    <= fbpa_pkg::SIZE_RST;
      bcount_r  <= fbpa_pkg::BCNT_RST;
      enable_r  <= fbpa_pkg::EN_RST;
      rebuild_r <= 1'b1;
    end else begin
      rebuild_r <= cfg_we;
      if (cfg_we) begin
        unique case (fbpa_pkg::cfg_reg_t'(cfg_index))
          fbpa_pkg::REG_BASE_ADDRESS: base_r   <= fbpa_pkg::ADDR_W'(cfg_data);
          fbpa_pkg::REG_BLOCK_SIZE:   size_r   <= cfg_data[fbpa_pkg::SIZE_W-1:0];
          fbpa_pkg::REG_BLOCK_COUNT:  bcount_r <= cfg_data[fbpa_pkg::BCNT_W-1:0];
          fbpa_pkg::REG_POOL_ENABLED: enable_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Blocks actually in the pool: zero when disabled, clipped to the depth.
  always_comb begin
    if (!enable_r) begin
      eff_n = '0;
    end else if (32'(bcount_r) > fbpa_pkg::MAX_BLOCKS) begin
      eff_n = fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
    end else begin
      eff_n = fbpa_pkg::CNT_W'(bcount_r);
    end
  end

  fbpa_free_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .rebuild (rebuild_r),
    .eff_n   (eff_n),
    .q_cmd   (q_cmd),
    .q_stat  (q_stat)
  );

  fbpa_addr_unit u_addr (
    .clk        (clk),
    .a_cmd      (a_cmd),
    .base_addr  (base_r),
    .stride     (size_r),
    .want_in    (in_release_address),
    .acc        (acc),
    .addr_match (addr_match)
  );

  fbpa_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .rebuild           (rebuild_r),
    .eff_n             (eff_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .addr_match        (addr_match),
    .acc               (acc),
    .q_stat            (q_stat),
    .q_cmd             (q_cmd),
    .a_cmd             (a_cmd),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_block_address (out_block_address),
    .out_free_blocks   (out_free_blocks)
  );

  // The free queue can never hold more indices than the pool has blocks.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !rebuild_r |-> (q_stat.count <= eff_n))
    else $error("free count exceeds pool size");

  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous one still in work");

  // Pop happens only at acceptance and push only at a scan hit.
  a_no_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_cmd.pop && q_cmd.push))
    else $error("simultaneous queue pop and push");

endmodule

`default_nettype wire

### test/fixed_block_pool_allocator_test.sv
// ============================================================================
// fixed_block_pool_allocator_test - self-checking bench for the block pool
// Drives allocate and free words against a cycle-free copy of the pool (free
// queue, in-use marks, register settings) and checks every result word in
// order. Covers register extremes, wraparound, aliased block addresses, empty
// and disabled pools, random traffic, back-pressure and sender pauses.
// ============================================================================
`default_nettype none

module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  // One expected result word, as the predictor works it out.
  typedef struct {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  free_cnt;
  } pool_answer_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_action;
  logic [ADDR_W-1:0]     in_release_address;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_ok;
  logic [ADDR_W-1:0]     out_block_address;
  logic [CNT_W-1:0]      out_free_blocks;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Register copies kept by the predictor.
  logic [ADDR_W-1:0]     pool_base;
  logic [SIZE_W-1:0]     pool_stride;
  logic [BCNT_W-1:0]     pool_blocks;
  logic                  pool_on;

  // Pool state kept by the predictor.
  logic [IDX_W-1:0]      free_fifo [MAX_BLOCKS];
  logic [IDX_W-1:0]      fifo_head;
  logic [IDX_W-1:0]      fifo_tail;
  logic [CNT_W-1:0]      free_left;
  logic                  block_held [MAX_BLOCKS];

  pool_answer_t          pending_answers [$];
  int                    mismatches;
  int                    hold_cycles;
  logic                  calm;

  fixed_block_pool_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_block_address  (out_block_address),
    .out_free_blocks    (out_free_blocks),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run must never take this long; a hang anywhere ends here.
  initial begin
    #(12 * 800000);
    $display("[fixed_block_pool_allocator] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Blocks that exist: the count register clamped to the pool depth, or none
  // at all while the pool is switched off.
  function automatic int live_blocks();
    int n;
    n = pool_on ? int'(pool_blocks) : 0;
    if (n > MAX_BLOCKS) begin
      n = MAX_BLOCKS;
    end
    return n;
  endfunction

  // Start of a block; the sum wraps at the address width like the hardware.
  function automatic logic [ADDR_W-1:0] block_start(input int idx);
    return pool_base + ADDR_W'(idx) * ADDR_W'(pool_stride);
  endfunction

  // Reset and every register write put the pool back to its initial shape:
  // all indices queued in ascending order and nothing held.
  task automatic rebuild_pool();
    int n;
    n = live_blocks();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free_fifo[i]  = IDX_W'(i);
      block_held[i] = 1'b0;
    end
    fifo_head = '0;
    fifo_tail = IDX_W'(n % MAX_BLOCKS);
    free_left = CNT_W'(n);
  endtask

  // Applies one accepted request to the pool copy and returns its answer.
  function automatic pool_answer_t pool_answer(input logic act,
                                               input logic [ADDR_W-1:0] addr);
    pool_answer_t ans;
    int           idx;
    int           n;
    ans.ok   = 1'b0;
    ans.addr = '0;
    if (act == ACT_ALLOC) begin
      // Oldest free index leaves the queue; an empty queue just fails.
      if (free_left != 0) begin
        idx             = int'(free_fifo[fifo_head]);
        fifo_head       = fifo_head + IDX_W'(1);
        free_left       = free_left - CNT_W'(1);
        block_held[idx] = 1'b1;
        ans.addr        = block_start(idx);
        ans.ok          = 1'b1;
      end
    end else begin
      // The lowest held block that starts at the address goes back to the
      // tail of the queue; aliased starts release one block per request.
      n = live_blocks();
      for (int i = 0; i < n; i++) begin
        if (!ans.ok && block_held[i] && block_start(i) == addr) begin
          block_held[i]        = 1'b0;
          free_fifo[fifo_tail] = IDX_W'(i);
          fifo_tail            = fifo_tail + IDX_W'(1);
          free_left            = free_left + CNT_W'(1);
          ans.ok               = 1'b1;
        end
      end
    end
    ans.free_cnt = free_left;
    return ans;
  endfunction

  // Random held block, or -1 when nothing is held.
  function automatic int pick_held_block();
    int held [$];
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (block_held[i]) begin
        held.push_back(i);
      end
    end
    if (held.size() == 0) begin
      return -1;
    end
    return held[$urandom_range(held.size() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Every result word that leaves the block is compared with the oldest
  // answer still waiting. Outputs are sampled at the rising edge, where the
  // stall driven at the previous falling edge is stable.
  initial begin
    pool_answer_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result word, ok", 64'(out_ok), 64'(0));
        end else begin
          want = pending_answers.pop_front();
          if (out_ok !== want.ok) begin
            report_mismatch("ok", 64'(out_ok), 64'(want.ok));
          end
          if (out_block_address !== want.addr) begin
            report_mismatch("block_address", 64'(out_block_address), 64'(want.addr));
          end
          if (out_free_blocks !== want.free_cnt) begin
            report_mismatch("free_blocks", 64'(out_free_blocks), 64'(want.free_cnt));
          end
        end
      end
    end
  end

  // Receiver side. A requested hold-off is counted down here one cycle at a
  // time; otherwise the stall is random unless a calm stretch is running.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall   <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 36);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one request word and returns at the edge that accepts it. Random
  // idle cycles go in front of the word; valid stays high while stalled so
  // the payload is held, and it is only lowered by the next caller.
  task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_release_address <= addr;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_answers.push_back(pool_answer(act, addr));
  endtask

  // Sender goes quiet until every answer has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Register writes happen only with the block idle. Unused upper data bits
  // carry random junk, which the block must drop.
  task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    wait_for_results();
    repeat (4) @(posedge clk);
    word = $urandom();
    case (sel)
      REG_BASE_ADDRESS: begin
        word = value;
      end
      REG_BLOCK_SIZE: begin
        word[SIZE_W-1:0] = value[SIZE_W-1:0];
      end
      REG_BLOCK_COUNT: begin
        word[BCNT_W-1:0] = value[BCNT_W-1:0];
      end
      default: begin
        word[0] = value[0];
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= word;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (sel)
      REG_BASE_ADDRESS: begin
        pool_base = word[ADDR_W-1:0];
      end
      REG_BLOCK_SIZE: begin
        pool_stride = word[SIZE_W-1:0];
      end
      REG_BLOCK_COUNT: begin
        pool_blocks = word[BCNT_W-1:0];
      end
      default: begin
        pool_on = word[0];
      end
    endcase
    rebuild_pool();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] stride,
                          input logic [BCNT_W-1:0] blocks, input logic on);
    write_register(REG_BASE_ADDRESS, CFG_DATA_W'(base));
    write_register(REG_BLOCK_SIZE, CFG_DATA_W'(stride));
    write_register(REG_BLOCK_COUNT, CFG_DATA_W'(blocks));
    write_register(REG_POOL_ENABLED, CFG_DATA_W'(on));
  endtask

  // Mostly well-formed traffic: allocations and frees of blocks that are
  // really held, in bursts leaning toward filling or draining the pool. The
  // rest is noise: random addresses, addresses off by 1 to 3 and double frees.
  task automatic run_traffic(input int words);
    int alloc_pct;
    int roll;
    int idx;
    alloc_pct = 50;
    for (int k = 0; k < words; k++) begin
      if (k % 20 == 0) begin
        alloc_pct = $urandom_range(20, 80);
      end
      roll = $urandom_range(99);
      idx  = pick_held_block();
      if (roll < alloc_pct) begin
        send_request(ACT_ALLOC, $urandom());
      end else if (roll < 88 && idx >= 0) begin
        send_request(ACT_FREE, block_start(idx));
      end else if (roll < 93 && idx >= 0) begin
        send_request(ACT_FREE, block_start(idx) + ADDR_W'($urandom_range(1, 3)));
      end else if (roll < 96) begin
        send_request(ACT_FREE, block_start($urandom_range(MAX_BLOCKS - 1)));
      end else begin
        send_request(ACT_FREE, $urandom());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked cases: first-in-first-out reuse after reset, double and
  // misaligned frees, address wrap at the top of the address space, an
  // empty pool, a zero stride where every block shares one start, a count
  // above the pool depth, a disabled pool and a pool of zero blocks.
  task automatic test_directed_cases();
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '1);
    send_request(ACT_FREE, ADDR_W'(64));
    send_request(ACT_FREE, ADDR_W'(64));
    send_request(ACT_FREE, ADDR_W'(5));
    send_request(ACT_ALLOC, '0);

    set_pool(32'hFFFF_FFC0, 16'h0020, 7'd3, 1'b1);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, '0);
    send_request(ACT_FREE, '1);

    set_pool(32'h1234_5678, 16'h0000, 7'd127, 1'b1);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, 32'h1234_5678);
    send_request(ACT_FREE, 32'h1234_5678);
    send_request(ACT_FREE, 32'h1234_5678);

    write_register(REG_POOL_ENABLED, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, 32'h1234_5678);

    set_pool(32'h0000_1000, 16'h0010, 7'd0, 1'b1);
    send_request(ACT_ALLOC, '0);
  endtask

  // Full pool, no idling on either side: back-to-back words.
  task automatic test_streaming();
    set_pool('0, 16'd64, 7'd64, 1'b1);
    calm = 1'b1;
    run_traffic(80);
    calm = 1'b0;
  endtask

  // The receiver holds off for a long while as the sender keeps offering,
  // so the result register fills and the block must stall its input.
  task automatic test_receiver_hold();
    calm        = 1'b1;
    hold_cycles = 400;
    run_traffic(20);
    calm = 1'b0;
  endtask

  // Short bursts, each followed by a pause until everything has drained.
  task automatic test_sender_pause();
    set_pool(32'h8000_0000, 16'd1, 7'd16, 1'b1);
    for (int b = 0; b < 6; b++) begin
      run_traffic($urandom_range(5, 15));
      wait_for_results();
    end
  endtask

  // Phases under different settings, extremes first and then random ones.
  task automatic test_random_setups();
    logic [SIZE_W-1:0] stride;
    logic [BCNT_W-1:0] blocks;
    set_pool(32'hFFFF_FFFF, 16'hFFFF, 7'd64, 1'b1);
    run_traffic(70);
    set_pool('0, 16'd1, 7'd1, 1'b1);
    run_traffic(40);
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(3))
        0: stride = SIZE_W'($urandom_range(1, 8));
        1: stride = 16'hFFFF;
        default: stride = SIZE_W'($urandom());
      endcase
      // Mostly small pools; now and then a count past the pool depth.
      blocks = ($urandom_range(4) == 0) ? BCNT_W'($urandom_range(65, 127))
                                        : BCNT_W'($urandom_range(1, 24));
      set_pool($urandom(), stride, blocks, $urandom_range(9) != 0);
      run_traffic(62);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    in_valid           = 1'b0;
    in_action          = ACT_ALLOC;
    in_release_address = '0;
    cfg_valid          = 1'b0;
    cfg_index          = REG_BASE_ADDRESS;
    cfg_data           = '0;
    rst_n              = 1'b0;
    mismatches         = 0;
    hold_cycles        = 0;
    calm               = 1'b0;
    pool_base          = BASE_RST;
    pool_stride        = SIZE_RST;
    pool_blocks        = BCNT_RST;
    pool_on            = EN_RST;
    rebuild_pool();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_streaming();
    test_receiver_hold();
    test_sender_pause();
    test_random_setups();

    // Drain, then give the block time to show any stray word.
    wait_for_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("[fixed_block_pool_allocator] OK");
    end else begin
      $display("[fixed_block_pool_allocator] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
